@@ design/assert_macros.svh @@
// Assertion macros used by the text console writer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle property violated");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle property violated");

`endif

@@ design/tcw_pkg.sv @@
// Package with the item types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int DEF_ROWS = 25;
  localparam int DEF_COLS = 80;
  localparam int CELL_W   = 16;
  localparam int CPOS_W   = 11;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h07;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
  } in_item_t;

  typedef struct packed {
    logic [CPOS_W-1:0] cursor_pos;
    logic [7:0]        cell_char;
    logic [7:0]        cell_attr;
  } out_item_t;

endpackage

`default_nettype wire

@@ design/tcw_screen_ram.sv @@
// Screen cell memory with one write port and one registered read port.
`default_nettype none

module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/tcw_ctrl.sv @@
// Sequencer of the text console writer with the shared row-times-columns address unit.
`default_nettype none

module tcw_ctrl #(
  parameter int ROWS = 25,
  parameter int COLS = 80,
  parameter int AW   = 11
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire tcw_pkg::in_item_t      in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output tcw_pkg::out_item_t          out_data_o,
  input  wire logic [7:0]             text_color_i,
  output logic                        ram_we_o,
  output logic [AW-1:0]               ram_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]  ram_wdata_o,
  output logic [AW-1:0]               ram_raddr_o,
  input  wire logic [tcw_pkg::CELL_W-1:0] ram_rdata_i
);

  import tcw_pkg::*;

  localparam int NCELLS = ROWS * COLS;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CLW    = $clog2(COLS + 1);
  localparam int LW     = $clog2(NCELLS + 1);

  typedef enum logic [3:0] {
    S_FILL, S_IDLE, S_WRAP, S_CHAR, S_SCROLL, S_DRAIN, S_CURS, S_RD, S_RDW, S_DONE
  } state_e;

  state_e            state_q, state_d;
  state_e            ret_q, ret_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [AW-1:0]     wr_addr_q, wr_addr_d;
  logic              copy_q, copy_d;
  logic              init_q, init_d;
  in_item_t          req_q, req_d;
  logic [CLW-1:0]    col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CPOS_W-1:0] hw_q, hw_d;
  logic [7:0]        cchar_q, cchar_d;
  logic [7:0]        cattr_q, cattr_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [RW-1:0]     op_row;
  logic [CLW-1:0]    op_col;
  logic [LW-1:0]     lin;
  logic [RW:0]       row_inc;
  logic [RW:0]       row_wrap;

  always_comb begin
    op_row = (state_q == S_RD) ? RW'(req_q.cell_row) : row_q;
    op_col = (state_q == S_RD) ? CLW'(req_q.cell_col) : col_q;
    lin    = LW'(LW'(op_row) * LW'(COLS)) + LW'(op_col);
  end

  always_comb begin
    row_inc  = {1'b0, row_q} + (RW+1)'(1);
    row_wrap = (32'(col_q) >= COLS) ? row_inc : {1'b0, row_q};
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    addr_d      = addr_q;
    wr_addr_d   = wr_addr_q;
    copy_d      = copy_q;
    init_d      = init_q;
    req_d       = req_q;
    col_d       = col_q;
    row_d       = row_q;
    hw_d        = hw_q;
    cchar_d     = cchar_q;
    cattr_d     = cattr_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q;
    ram_wdata_o = {text_color_i, SPACE_CODE};
    ram_raddr_o = lin[AW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_FILL: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = addr_q;
        ram_wdata_o = init_q ? {RESET_COLOR, SPACE_CODE} : {text_color_i, SPACE_CODE};
        if (addr_q == AW'(NCELLS - 1)) begin
          init_d  = 1'b0;
          state_d = ret_q;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          cchar_d = 8'd0;
          cattr_d = 8'd0;
          case (in_data_i.func)
            FUNC_PUT: begin
              state_d = S_WRAP;
            end
            FUNC_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              addr_d  = '0;
              ret_d   = S_DONE;
              state_d = S_FILL;
            end
            FUNC_READ: begin
              if ((32'(in_data_i.cell_row) < ROWS) && (32'(in_data_i.cell_col) < COLS)) begin
                state_d = S_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_WRAP: begin
        if (32'(col_q) >= COLS) begin
          col_d = '0;
        end
        if (32'(row_wrap) >= ROWS) begin
          row_d   = RW'(ROWS - 1);
          addr_d  = '0;
          copy_d  = 1'b0;
          ret_d   = S_CHAR;
          state_d = S_SCROLL;
        end else begin
          row_d   = row_wrap[RW-1:0];
          state_d = S_CHAR;
        end
      end
      S_CHAR: begin
        if (req_q.char_code == NEWLINE_CODE) begin
          col_d = '0;
          if (32'(row_inc) >= ROWS) begin
            row_d   = RW'(ROWS - 1);
            addr_d  = '0;
            copy_d  = 1'b0;
            ret_d   = S_CURS;
            state_d = S_SCROLL;
          end else begin
            row_d   = row_inc[RW-1:0];
            state_d = S_CURS;
          end
        end else begin
          ram_we_o    = 1'b1;
          ram_waddr_o = lin[AW-1:0];
          ram_wdata_o = {text_color_i, req_q.char_code};
          col_d       = col_q + CLW'(1);
          state_d     = S_CURS;
        end
      end
      S_SCROLL: begin
        ram_raddr_o = addr_q + AW'(COLS);
        ram_we_o    = copy_q;
        ram_waddr_o = wr_addr_q;
        ram_wdata_o = ram_rdata_i;
        wr_addr_d   = addr_q;
        copy_d      = 1'b1;
        addr_d      = addr_q + AW'(1);
        if (addr_q == AW'(NCELLS - COLS - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = wr_addr_q;
        ram_wdata_o = ram_rdata_i;
        copy_d      = 1'b0;
        state_d     = S_FILL;
      end
      S_CURS: begin
        hw_d    = CPOS_W'(lin);
        state_d = S_DONE;
      end
      S_RD: begin
        state_d = S_RDW;
      end
      S_RDW: begin
        cchar_d = ram_rdata_i[7:0];
        cattr_d = ram_rdata_i[15:8];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.cursor_pos = hw_q;
          out_d.cell_char  = cchar_q;
          out_d.cell_attr  = cattr_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      ret_q       <= S_IDLE;
      addr_q      <= '0;
      wr_addr_q   <= '0;
      copy_q      <= 1'b0;
      init_q      <= 1'b1;
      req_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      hw_q        <= '0;
      cchar_q     <= '0;
      cattr_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      addr_q      <= addr_d;
      wr_addr_q   <= wr_addr_d;
      copy_q      <= copy_d;
      init_q      <= init_d;
      req_q       <= req_d;
      col_q       <= col_d;
      row_q       <= row_d;
      hw_q        <= hw_d;
      cchar_q     <= cchar_d;
      cattr_q     <= cattr_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ design/text_console_writer_core.sv @@
// Top level of the text console writer: colour register, sequencer and screen memory.
//
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid_i/in_stall_o  in_data_i  (func, char, cell position)
//   out       output     out_valid_o/out_stall_i out_data_o (cursor, cell char, attr)
//   cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (text colour)
//
// A plain character passes the wrap, character, cursor and done states, and a cell read
// the read, read-wait and done states, before its result is registered. The length of
// a scroll or a clear is set by the single write port of the screen memory, which is
// swept one cell a cycle. After reset the memory is filled with blank cells before any
// input transfer is taken; configuration writes are taken at all times.
// A finished result waits in the output register while the next item is taken.
`default_nettype none
`include "assert_macros.svh"

module text_console_writer_core #(
  parameter int ROWS = tcw_pkg::DEF_ROWS,
  parameter int COLS = tcw_pkg::DEF_COLS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tcw_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tcw_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_data_i
);

  import tcw_pkg::*;

  localparam int NCELLS = ROWS * COLS;
  localparam int AW     = $clog2(NCELLS);

  logic [7:0]        text_color_q;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= RESET_COLOR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      text_color_q <= cfg_data_i;
    end
  end

  tcw_ctrl #(
    .ROWS(ROWS),
    .COLS(COLS),
    .AW  (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .text_color_i(text_color_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tcw_screen_ram #(
    .DEPTH(NCELLS),
    .AW   (AW),
    .DW   (CELL_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_NEXT(a_color_written, cfg_valid_i && cfg_ready_o, text_color_q == $past(cfg_data_i))
  `ASSERT_IMPL(a_write_in_range, ram_we, 32'(ram_waddr) < NCELLS)

endmodule

`default_nettype wire

@@ tb/tb_text_console_writer_core.sv @@
// Self-checking testbench for the text console writer core, with a scoreboard class.
import tcw_pkg::*;

class console_scoreboard;
  localparam int NROWS = DEF_ROWS;
  localparam int NCOLS = DEF_COLS;

  logic [15:0] cells [NROWS*NCOLS];
  int unsigned col;
  int unsigned row;
  logic [CPOS_W-1:0] hw_pos;
  logic [7:0] colour;
  out_item_t expected_q[$];
  int unsigned failures;

  function new();
    foreach (cells[i]) cells[i] = {RESET_COLOR, SPACE_CODE};
    col = 0;
    row = 0;
    hw_pos = '0;
    colour = RESET_COLOR;
    failures = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void report(string msg);
    failures++;
    if (failures <= 10) $display("mismatch: %s", msg);
  endfunction

  function void scroll_up();
    for (int i = 0; i < (NROWS - 1) * NCOLS; i++) cells[i] = cells[i + NCOLS];
    for (int c = 0; c < NCOLS; c++) cells[(NROWS - 1) * NCOLS + c] = {colour, SPACE_CODE};
  endfunction

  // Works out the result of one accepted input transfer and queues it.
  function void note_input(in_item_t it);
    out_item_t res;
    logic [15:0] entry;
    res = '0;
    case (it.func)
      FUNC_PUT: begin
        if (col >= NCOLS) begin
          col = 0;
          row++;
        end
        if (row >= NROWS) begin
          row = NROWS - 1;
          scroll_up();
        end
        if (it.char_code == NEWLINE_CODE) begin
          row++;
          col = 0;
          if (row >= NROWS) begin
            row = NROWS - 1;
            scroll_up();
          end
        end else begin
          cells[row * NCOLS + col] = {colour, it.char_code};
          col++;
        end
        hw_pos = CPOS_W'(col + row * NCOLS);
      end
      FUNC_CLEAR: begin
        col = 0;
        row = 0;
        foreach (cells[i]) cells[i] = {colour, SPACE_CODE};
      end
      FUNC_READ: begin
        if (it.cell_row < NROWS && it.cell_col < NCOLS) begin
          entry = cells[it.cell_row * NCOLS + it.cell_col];
          res.cell_char = entry[7:0];
          res.cell_attr = entry[15:8];
        end
      end
      default: ;
    endcase
    res.cursor_pos = hw_pos;
    expected_q.push_back(res);
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result cursor %0d char %h attr %h",
                       got.cursor_pos, got.cell_char, got.cell_attr));
      return;
    end
    want = expected_q.pop_front();
    if (got.cursor_pos !== want.cursor_pos || got.cell_char !== want.cell_char ||
        got.cell_attr !== want.cell_attr)
      report($sformatf("expected cursor %0d char %h attr %h, got cursor %0d char %h attr %h",
                       want.cursor_pos, want.cell_char, want.cell_attr,
                       got.cursor_pos, got.cell_char, got.cell_attr));
  endfunction
endclass

module tb_text_console_writer_core;
  localparam int CYCLE_LIMIT = 30_000_000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 180;
  localparam logic [1:0] FUNC_IDLE = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_item_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_item_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [7:0] cfg_data_i;

  console_scoreboard board;
  bit calm;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned newline_pct;

  text_console_writer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output side: check each result transfer, then hold off for a random while.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(out_data_o);
      stall_left = draw_wait();
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_op(input logic [1:0] func, input logic [7:0] ch,
                         input logic [4:0] r, input logic [6:0] c);
    int unsigned gap;
    in_item_t it;
    gap = draw_wait();
    it.func = func;
    it.char_code = ch;
    it.cell_row = r;
    it.cell_col = c;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic write_colour(input logic [7:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.colour = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [7:0] ch;
    logic [4:0] r;
    logic [6:0] c;
    pick = $urandom_range(0, 99);
    ch = $urandom_range(0, 255);
    r = $urandom_range(0, 31);
    c = $urandom_range(0, 127);
    if (pick < 60) begin
      if ($urandom_range(0, 99) < newline_pct) ch = NEWLINE_CODE;
      send_op(FUNC_PUT, ch, r, c);
    end else if (pick < 61) begin
      send_op(FUNC_CLEAR, ch, r, c);
    end else if (pick < 95) begin
      if ($urandom_range(0, 99) < 85) begin
        r = $urandom_range(0, DEF_ROWS - 1);
        c = $urandom_range(0, DEF_COLS - 1);
      end
      send_op(FUNC_READ, ch, r, c);
    end else begin
      send_op(FUNC_IDLE, ch, r, c);
    end
  endtask

  initial begin
    logic [7:0] colour_val;
    board = new();
    calm = 1'b0;
    stall_left = 0;
    cycle_count = 0;
    newline_pct = 10;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(FUNC_READ, 8'h00, 5'd0, 7'd0);
    send_op(FUNC_PUT, 8'h41, 5'd0, 7'd0);
    send_op(FUNC_PUT, 8'h00, 5'd31, 7'd127);
    send_op(FUNC_PUT, 8'hFF, 5'd0, 7'd0);
    send_op(FUNC_READ, 8'hFF, 5'd0, 7'd1);
    send_op(FUNC_READ, 8'h00, 5'd0, 7'd2);
    send_op(FUNC_PUT, NEWLINE_CODE, 5'd0, 7'd0);
    send_op(FUNC_PUT, 8'h7E, 5'd0, 7'd0);
    send_op(FUNC_READ, 8'h00, 5'd1, 7'd0);
    send_op(FUNC_READ, 8'h00, 5'd24, 7'd79);
    send_op(FUNC_READ, 8'h00, 5'd24, 7'd80);
    send_op(FUNC_READ, 8'h00, 5'd25, 7'd0);
    send_op(FUNC_READ, 8'hFF, 5'd31, 7'd127);
    send_op(FUNC_IDLE, 8'hFF, 5'd31, 7'd127);
    send_op(FUNC_CLEAR, 8'hFF, 5'd31, 7'd127);
    send_op(FUNC_READ, 8'h00, 5'd1, 7'd0);
    send_op(FUNC_PUT, NEWLINE_CODE, 5'd0, 7'd0);

    // Each phase sets a colour and one of three newline densities, so that both long
    // wrapped lines and frequent scrolling are reached.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: colour_val = 8'h00;
        1: colour_val = 8'hFF;
        5: colour_val = RESET_COLOR;
        default: colour_val = $urandom_range(0, 255);
      endcase
      write_colour(colour_val);
      case (p % 3)
        0: newline_pct = 40;
        1: newline_pct = 2;
        default: newline_pct = 15;
      endcase
      calm = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 49) == 0) wait_drained();
        send_random();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+design
design/tcw_pkg.sv
design/tcw_screen_ram.sv
design/tcw_ctrl.sv
design/text_console_writer_core.sv
tb/tb_text_console_writer_core.sv
